### design/cqm_pkg.sv
// ----------------------------------------------------------------------------
// cqm_pkg
// Shared types and constants for the circular queue with running mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqm_pkg;

    // default number of storage slots (one is always left free)
    localparam int QUEUE_SLOTS_DEF = 6;

    // field widths
    localparam int TAG_W    = 32;
    localparam int HEIGHT_W = 12;
    localparam int MEAN_W   = 12;

    // divider: quotient bits resolved per cycle
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = MEAN_W / DIV_BITS;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // input item
    typedef struct packed {
        logic                opcode;
        logic [TAG_W-1:0]    item_tag;
        logic [HEIGHT_W-1:0] item_height;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [MEAN_W-1:0] mean_height;
        logic [TAG_W-1:0]  removed_tag;
        logic              empty_error;
    } out_item_t;

    // one queue entry as held in the store
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [HEIGHT_W-1:0] height;
    } entry_t;

endpackage

### design/cqm_store.sv
// ----------------------------------------------------------------------------
// cqm_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqm_store #(
    parameter int DEPTH = cqm_pkg::QUEUE_SLOTS_DEF,
    parameter int IDX_W = $clog2(cqm_pkg::QUEUE_SLOTS_DEF)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  cqm_pkg::entry_t    wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output cqm_pkg::entry_t    rd_data
);
    import cqm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/cqm_div.sv
// ----------------------------------------------------------------------------
// cqm_div
// Iterative divider for the rounded mean: (2*sum + n) / (2*n), a few
// quotient bits per cycle by restoring compare and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqm_div #(
    parameter int CNT_W = $clog2(cqm_pkg::QUEUE_SLOTS_DEF),
    parameter int SUM_W = cqm_pkg::HEIGHT_W + $clog2(cqm_pkg::QUEUE_SLOTS_DEF)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [SUM_W-1:0]           sum,
    input  logic [CNT_W-1:0]           count,
    output logic                       done,
    output logic [cqm_pkg::MEAN_W-1:0] quotient
);
    import cqm_pkg::*;

    localparam int DVD_W  = SUM_W + 2;
    localparam int DS_W   = CNT_W + MEAN_W;
    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic [DVD_W-1:0]  rem_reg,  rem_next;
    logic [DS_W-1:0]   dsr_reg,  dsr_next;
    logic [MEAN_W-1:0] q_reg,    q_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    // dividend and divisor aligned to the top quotient bit
    logic [DVD_W-1:0] dividend;
    logic [DS_W-1:0]  divisor_top;

    assign dividend    = {1'b0, sum, 1'b0} + DVD_W'(count);
    assign divisor_top = DS_W'({count, 1'b0}) << (MEAN_W - 1);

    // DIV_BITS restoring steps per cycle
    always_comb begin
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        q_next   = q_reg;
        for (int j = 0; j < DIV_BITS; j++) begin
            q_next = {q_next[MEAN_W-2:0], 1'b0};
            if (rem_next >= DVD_W'(dsr_next)) begin
                rem_next  = rem_next - DVD_W'(dsr_next);
                q_next[0] = 1'b1;
            end
            dsr_next = dsr_next >> 1;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsr_reg <= divisor_top;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dsr_reg <= dsr_next;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### design/circular_queue_with_mean.sv
// ----------------------------------------------------------------------------
// circular_queue_with_mean
// Drop-oldest circular queue of tagged heights with a rounded running mean.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one operation: insert (tag, height) or
//   remove oldest. Each item yields exactly one result on m_valid/m_ready/
//   m_item. An insert reports the mean height of the held entries rounded
//   half up; a full queue drops its oldest entry first. A remove reports the
//   popped tag, or raises empty_error on an empty queue and changes nothing.
//   Entries sit in a single-port-read memory; the head entry is read in the
//   cycle before it is used. The mean comes from a running sum through an
//   iterative divider resolving three quotient bits per cycle. An insert
//   starts the divider and waits in ST_DIV before ST_OUT; an insert into a
//   full queue first reads the head in ST_READ; a remove passes ST_READ and
//   ST_OUT, a remove on empty goes straight to ST_OUT. One item is worked at a
//   time; s_ready returns as the result is loaded into the output register.
//   The output register lets the next item be accepted while a result waits;
//   if the receiver stalls, a further result is held back and s_ready drops.
//   Reset (aresetn low, synchronous) empties the queue and drops any result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_queue_with_mean #(
    parameter int QUEUE_SLOTS = cqm_pkg::QUEUE_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cqm_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output cqm_pkg::out_item_t m_item
);
    import cqm_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_SLOTS);
    localparam int CNT_W = $clog2(QUEUE_SLOTS);
    localparam int SUM_W = HEIGHT_W + CNT_W;

    // sequencer states
    localparam int         ST_W    = 2;
    localparam [ST_W-1:0]  ST_IDLE = 2'd0;
    localparam [ST_W-1:0]  ST_READ = 2'd1;
    localparam [ST_W-1:0]  ST_DIV  = 2'd2;
    localparam [ST_W-1:0]  ST_OUT  = 2'd3;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [IDX_W-1:0] head_reg,  head_next;
    logic [IDX_W-1:0] tail_reg,  tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg,   sum_next;
    logic             m_valid_reg, m_valid_next;
    in_item_t         in_reg;
    out_item_t        res_reg, res_next;
    out_item_t        m_item_reg;

    logic             s_accept;
    logic             m_load;
    logic             full;
    logic             empty;

    // memory and divider hookup
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    entry_t           rd_data;
    logic             div_start;
    logic             div_done;
    logic [MEAN_W-1:0] div_quot;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign full     = (count_reg == CNT_W'(QUEUE_SLOTS - 1));
    assign empty    = (count_reg == '0);

    // entry store
    cqm_store #(
        .DEPTH (QUEUE_SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // mean divider
    cqm_div #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .sum      (sum_next),
        .count    (count_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer: read head, modify sum and pointers, write tail, run divider, load output
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        wr_data    = '{tag: s_item.item_tag, height: s_item.item_height};
        rd_en      = 1'b0;
        div_start  = 1'b0;
        m_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.opcode == OP_REMOVE) begin
                        if (empty) begin
                            res_next   = '{mean_height: '0, removed_tag: '0, empty_error: 1'b1};
                            state_next = ST_OUT;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                    end else if (full) begin
                        // oldest height must come out of the sum first
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        wr_en      = 1'b1;
                        sum_next   = sum_reg + SUM_W'(s_item.item_height);
                        tail_next  = next_idx(tail_reg);
                        count_next = count_reg + 1'b1;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_READ: begin
                head_next = next_idx(head_reg);
                if (in_reg.opcode == OP_REMOVE) begin
                    sum_next   = sum_reg - SUM_W'(rd_data.height);
                    count_next = count_reg - 1'b1;
                    res_next   = '{mean_height: '0, removed_tag: rd_data.tag, empty_error: 1'b0};
                    state_next = ST_OUT;
                end else begin
                    // drop oldest, then insert; count stays at full
                    sum_next   = sum_reg - SUM_W'(rd_data.height)
                               + SUM_W'(in_reg.item_height);
                    wr_en      = 1'b1;
                    wr_data    = '{tag: in_reg.item_tag, height: in_reg.item_height};
                    tail_next  = next_idx(tail_reg);
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = '{mean_height: div_quot, removed_tag: '0, empty_error: 1'b0};
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_item;
        end
        res_reg <= res_next;
        if (m_load) begin
            m_item_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### design/cqm_checker.sv
// ----------------------------------------------------------------------------
// cqm_checker
// Port-level checks for the circular queue with running mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cqm_pkg::out_item_t m_item
);
    import cqm_pkg::*;

    logic [1:0] pend_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // items accepted whose result is not yet taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + {1'b0, s_acc} - {1'b0, m_acc};
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // no result without an item behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result with no outstanding item");

    // at most one item in work and one result waiting
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many outstanding items");

    // an error result carries no mean and no tag
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.empty_error |-> m_item.removed_tag == '0 && m_item.mean_height == '0)
        else $error("error result with payload");

    // reset drops the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind circular_queue_with_mean cqm_checker u_cqm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
